// ===== hw/rtl/etmr_pkg.sv =====
// Shared types and constants for the expiry timer table.
// Used by etmr_cell, etmr_emit and expiry_timer_table; no dependencies.
`timescale 1ns / 1ps

package etmr_pkg;

    localparam int SLOTS_DEF = 32;

    localparam int TPS_W     = 14;
    localparam int SEC_W     = 16;
    localparam int OWNER_W   = 16;
    localparam int SLOT_W    = 5;
    localparam int KIND_W    = 2;
    localparam int TICK_W    = 32;
    localparam int PROD_W    = SEC_W + TPS_W;

    localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(100);

    // command codes on the input side
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SET  = 1'b1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_SET     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FULL    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRED = 2'd2;

    // command token that walks down the chain of cells
    typedef struct packed {
        logic               valid;
        logic               cmd;
        logic               claimed;   // a set already took a slot upstream
        logic [TICK_W-1:0]  value;     // expiry for set, new count for tick
        logic [OWNER_W-1:0] owner;
    } t_tok;

    // per-cell event, at most one cell fires per cycle
    typedef struct packed {
        logic               hit;
        logic [KIND_W-1:0]  kind;
        logic [OWNER_W-1:0] owner;
    } t_hit;

    // merged event of the whole chain
    typedef struct packed {
        logic               hit;
        logic [KIND_W-1:0]  kind;
        logic [OWNER_W-1:0] owner;
        logic [SLOT_W-1:0]  slot;
    } t_evt;

    // token leaving the far end of the chain
    typedef struct packed {
        logic               valid;
        logic               full;
        logic [OWNER_W-1:0] owner;
    } t_fin;

endpackage

// ===== hw/rtl/etmr_cell.sv =====
// One timer slot of the chain: active flag, expiry and owner.
// Depends on etmr_pkg for the token and event types.
`timescale 1ns / 1ps

module etmr_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  etmr_pkg::t_tok i_tok,
    output etmr_pkg::t_tok o_tok,
    output etmr_pkg::t_hit o_hit
);

    logic                         r_active;
    logic [etmr_pkg::TICK_W-1:0]  r_expiry;
    logic [etmr_pkg::OWNER_W-1:0] r_owner;
    etmr_pkg::t_tok               r_tok;
    etmr_pkg::t_tok               n_tok;

    logic set_hit;
    logic exp_hit;

    assign set_hit = i_tok.valid && (i_tok.cmd == etmr_pkg::CMD_SET) &&
                     !i_tok.claimed && !r_active;
    // due when the expiry is not above the new count
    assign exp_hit = i_tok.valid && (i_tok.cmd == etmr_pkg::CMD_TICK) &&
                     r_active && !(r_expiry > i_tok.value);

    always_comb begin
        o_hit.hit   = set_hit || exp_hit;
        o_hit.kind  = set_hit ? etmr_pkg::KIND_SET : etmr_pkg::KIND_EXPIRED;
        o_hit.owner = set_hit ? i_tok.owner : r_owner;
    end

    // pass the token on, marked as claimed once a set took this slot
    always_comb begin
        n_tok         = i_tok;
        n_tok.claimed = i_tok.claimed || set_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_tok <= n_tok;
            if (set_hit) begin
                r_active <= 1'b1;
            end else if (exp_hit) begin
                r_active <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && set_hit) begin
            r_expiry <= i_tok.value;
            r_owner  <= i_tok.owner;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== hw/rtl/etmr_emit.sv =====
// Result stage: holds back one event to mark the last one, then an output register.
// Depends on etmr_pkg for the event types and result kinds.
`timescale 1ns / 1ps

module etmr_emit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  etmr_pkg::t_evt                i_evt,
    input  etmr_pkg::t_fin                i_fin,
    output logic                          o_adv,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [etmr_pkg::KIND_W-1:0]   o_kind,
    output logic [etmr_pkg::OWNER_W-1:0]  o_owner,
    output logic [etmr_pkg::SLOT_W-1:0]   o_slot,
    output logic                          o_last
);

    logic                          r_pend_valid;
    etmr_pkg::t_evt                r_pend;
    logic                          r_out_valid;
    logic [etmr_pkg::KIND_W-1:0]   r_out_kind;
    logic [etmr_pkg::OWNER_W-1:0]  r_out_owner;
    logic [etmr_pkg::SLOT_W-1:0]   r_out_slot;
    logic                          r_out_last;

    logic push;

    // move the chain only when the output register can take a result
    assign o_adv = !r_out_valid || i_ready;
    assign push  = o_adv && ((i_evt.hit && r_pend_valid) ||
                             (i_fin.valid && (r_pend_valid || i_fin.full)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_adv && i_evt.hit) begin
                r_pend_valid <= 1'b1;
            end else if (o_adv && i_fin.valid) begin
                r_pend_valid <= 1'b0;
            end
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_evt.hit) begin
            r_pend <= i_evt;
        end
        if (push) begin
            if (r_pend_valid) begin
                r_out_kind  <= r_pend.kind;
                r_out_owner <= r_pend.owner;
                r_out_slot  <= r_pend.slot;
                r_out_last  <= i_fin.valid;
            end else begin
                r_out_kind  <= etmr_pkg::KIND_FULL;
                r_out_owner <= i_fin.owner;
                r_out_slot  <= '0;
                r_out_last  <= 1'b1;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_kind  = r_out_kind;
    assign o_owner = r_out_owner;
    assign o_slot  = r_out_slot;
    assign o_last  = r_out_last;

endmodule

// ===== hw/rtl/expiry_timer_table.sv =====
// Expiry timer table top: multiply stage, chain of slot cells and result stage.
// Depends on etmr_pkg, etmr_cell and etmr_emit.
// A command passes the multiply stage, the stage that forms its token, and then the cell
// chain slot by slot; the result stage holds events back and registers them at its output.
// The block takes no new command until the token of the last one has left the chain,
// and the output side can stall the chain.
// Reset (i_rst_n low, synchronous): count zero, all slots free, ticks per second 100.
`timescale 1ns / 1ps

module expiry_timer_table #(
    parameter int SLOTS = etmr_pkg::SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration: ticks per second
    input  logic                        i_cfg_we,
    input  logic [etmr_pkg::TPS_W-1:0]  i_cfg_wdata,
    // command stream
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [31:0]                 s_axis_tdata,   // [15:0] seconds, [31:16] owner
    input  logic                        s_axis_tuser,   // cmd
    // result stream
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [23:0]                 m_axis_tdata,   // [15:0] owner_id, [20:16] slot, zero
    output logic [1:0]                  m_axis_tuser,   // kind
    output logic                        m_axis_tlast
);

    logic [etmr_pkg::TPS_W-1:0]   r_tps;
    logic [etmr_pkg::TICK_W-1:0]  r_tick;
    logic                         r_busy;

    // front stage: product of seconds and rate
    logic                         r_a_valid;
    logic                         r_a_cmd;
    logic [etmr_pkg::OWNER_W-1:0] r_a_owner;
    logic [etmr_pkg::PROD_W-1:0]  r_a_prod;

    etmr_pkg::t_tok r_tok0;
    etmr_pkg::t_tok tok [SLOTS+1];
    etmr_pkg::t_hit hit [SLOTS];
    etmr_pkg::t_evt evt;
    etmr_pkg::t_fin fin;

    logic adv;
    logic accept;
    logic done;

    logic [etmr_pkg::KIND_W-1:0]  out_kind;
    logic [etmr_pkg::OWNER_W-1:0] out_owner;
    logic [etmr_pkg::SLOT_W-1:0]  out_slot;

    // one command in flight: take the next once its token has left the chain
    assign s_axis_tready = !r_busy;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign done          = adv && tok[SLOTS].valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= etmr_pkg::TPS_RESET;
        end else if (i_cfg_we) begin
            r_tps <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (accept) begin
            r_busy <= 1'b1;
        end else if (done) begin
            r_busy <= 1'b0;
        end
    end

    // capture the command and register the multiply
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (accept) begin
            r_a_valid <= 1'b1;
        end else if (adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_cmd   <= s_axis_tuser;
            r_a_owner <= s_axis_tdata[31:16];
            r_a_prod  <= etmr_pkg::PROD_W'(s_axis_tdata[15:0]) *
                         etmr_pkg::PROD_W'(r_tps);
        end
    end

    // second stage: form the expiry, or advance the count for a tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick       <= '0;
            r_tok0.valid <= 1'b0;
        end else if (adv) begin
            r_tok0.valid <= r_a_valid;
            if (r_a_valid) begin
                r_tok0.cmd     <= r_a_cmd;
                r_tok0.claimed <= 1'b0;
                r_tok0.owner   <= r_a_owner;
                if (r_a_cmd == etmr_pkg::CMD_SET) begin
                    r_tok0.value <= etmr_pkg::TICK_W'(r_a_prod) + r_tick;
                end else begin
                    r_tok0.value <= r_tick + etmr_pkg::TICK_W'(1);
                    r_tick       <= r_tick + etmr_pkg::TICK_W'(1);
                end
            end
        end
    end

    assign tok[0] = r_tok0;

    // the slot chain: the token visits the slots in order from slot 0, so events come in slot order
    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        etmr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_tok   (tok[k]),
            .o_tok   (tok[k+1]),
            .o_hit   (hit[k])
        );
    end

    // merge the per-slot events; only the cell holding the token can fire
    always_comb begin
        evt = '0;
        for (int k = 0; k < SLOTS; k++) begin
            if (hit[k].hit) begin
                evt.hit   = 1'b1;
                evt.kind  = evt.kind | hit[k].kind;
                evt.owner = evt.owner | hit[k].owner;
                evt.slot  = evt.slot | etmr_pkg::SLOT_W'(k);
            end
        end
    end

    // a set that reaches the far end unclaimed found the table full
    always_comb begin
        fin.valid = tok[SLOTS].valid;
        fin.full  = (tok[SLOTS].cmd == etmr_pkg::CMD_SET) && !tok[SLOTS].claimed;
        fin.owner = tok[SLOTS].owner;
    end

    etmr_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (evt),
        .i_fin   (fin),
        .o_adv   (adv),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_kind  (out_kind),
        .o_owner (out_owner),
        .o_slot  (out_slot),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tuser = out_kind;
    assign m_axis_tdata = {3'b000, out_slot, out_owner};

endmodule

// ===== tb/tb_expiry_timer_table.sv =====
// Self-checking testbench for expiry_timer_table: directed and random set/tick commands.
// A scoreboard class predicts the result stream; depends on etmr_pkg and the block's RTL.
`timescale 1ns / 1ps

// One result transaction as seen on the master side.
typedef struct packed {
    logic [etmr_pkg::KIND_W-1:0]  kind;
    logic [etmr_pkg::OWNER_W-1:0] owner_id;
    logic [etmr_pkg::SLOT_W-1:0]  slot;
    logic                         last;
} t_timer_event;

// Tracks the timer table and queues the events each accepted command must produce.
class t_timer_scoreboard;
    logic [etmr_pkg::TPS_W-1:0]     ticks_per_sec;
    logic [etmr_pkg::TICK_W-1:0]    now_ticks;
    logic [etmr_pkg::SLOTS_DEF-1:0] armed;
    logic [etmr_pkg::TICK_W-1:0]    due_at [etmr_pkg::SLOTS_DEF];
    logic [etmr_pkg::OWNER_W-1:0]   holder [etmr_pkg::SLOTS_DEF];
    t_timer_event                   awaited[$];
    int                             errors;

    function new();
        ticks_per_sec = etmr_pkg::TPS_RESET;
        now_ticks     = '0;
        armed         = '0;
        errors        = 0;
    endfunction

    function void set_rate(logic [etmr_pkg::TPS_W-1:0] rate);
        ticks_per_sec = rate;
    endfunction

    function void note_command(logic cmd, logic [etmr_pkg::SEC_W-1:0] seconds,
                               logic [etmr_pkg::OWNER_W-1:0] owner);
        t_timer_event                   ev;
        logic [etmr_pkg::SLOTS_DEF-1:0] due_mask;
        logic [etmr_pkg::TICK_W-1:0]    span;
        if (cmd == etmr_pkg::CMD_SET) begin
            // take the lowest free slot, or refuse with slot zero
            span = etmr_pkg::TICK_W'(seconds) * etmr_pkg::TICK_W'(ticks_per_sec);
            ev   = '{kind: etmr_pkg::KIND_FULL, owner_id: owner, slot: '0, last: 1'b1};
            for (int i = 0; i < etmr_pkg::SLOTS_DEF; i++) begin
                if (!armed[i] && ev.kind == etmr_pkg::KIND_FULL) begin
                    armed[i]  = 1'b1;
                    due_at[i] = span + now_ticks;
                    holder[i] = owner;
                    ev.kind   = etmr_pkg::KIND_SET;
                    ev.slot   = etmr_pkg::SLOT_W'(i);
                end
            end
            awaited.push_back(ev);
        end else begin
            now_ticks = now_ticks + etmr_pkg::TICK_W'(1);
            due_mask  = '0;
            for (int i = 0; i < etmr_pkg::SLOTS_DEF; i++)
                due_mask[i] = armed[i] && (due_at[i] <= now_ticks);
            armed = armed & ~due_mask;
            // report in slot order, last on the highest due slot
            for (int i = 0; i < etmr_pkg::SLOTS_DEF; i++) begin
                if (due_mask[i]) begin
                    due_mask[i] = 1'b0;
                    ev = '{kind: etmr_pkg::KIND_EXPIRED, owner_id: holder[i],
                           slot: etmr_pkg::SLOT_W'(i), last: (due_mask == '0)};
                    awaited.push_back(ev);
                end
            end
        end
    endfunction

    function void check_result(t_timer_event got);
        t_timer_event want;
        if (awaited.size() == 0) begin
            errors++;
            $display("%0t: result with none pending: kind %0d owner %h slot %0d last %0b",
                     $time, got.kind, got.owner_id, got.slot, got.last);
            return;
        end
        want = awaited.pop_front();
        if (got !== want) begin
            errors++;
            $display("%0t: mismatch: expected kind %0d owner %h slot %0d last %0b,",
                     $time, want.kind, want.owner_id, want.slot, want.last,
                     " got kind %0d owner %h slot %0d last %0b",
                     got.kind, got.owner_id, got.slot, got.last);
        end
    endfunction

    function int pending();
        return awaited.size();
    endfunction
endclass

module tb_expiry_timer_table;

    localparam int TABLE_SLOTS  = etmr_pkg::SLOTS_DEF;
    // a tick with nothing due leaves the block busy while its token walks the chain
    localparam int DRAIN_CYCLES = TABLE_SLOTS + 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 5000;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [etmr_pkg::TPS_W-1:0]     i_cfg_wdata;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [31:0]                    s_axis_tdata;   // [15:0] seconds, [31:16] owner
    logic                           s_axis_tuser;   // cmd
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [23:0]                    m_axis_tdata;   // [15:0] owner_id, [20:16] slot, zero fill
    logic [1:0]                     m_axis_tuser;   // kind
    logic                           m_axis_tlast;

    t_timer_scoreboard     sb;
    int                    tx_quiet;
    int                    rx_quiet;
    bit                    hold_output;

    expiry_timer_table u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Draw the idle cycles before one transaction, with occasional stretches of
    // back-to-back transactions.
    function automatic int draw_wait(inout int quiet_left);
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            quiet_left = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    // Offer one command and hold it until the block takes it; keep tvalid high on
    // return so a zero-gap follow-up needs no lowering.
    task automatic send_cmd(input logic cmd, input logic [etmr_pkg::SEC_W-1:0] seconds,
                            input logic [etmr_pkg::OWNER_W-1:0] owner);
        int gap;
        gap = draw_wait(tx_quiet);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {owner, seconds};
        s_axis_tuser  = cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_command(cmd, seconds, owner);
    endtask

    // Send a stream of random commands; tick_pct sets the share of ticks and
    // sec_max bounds the requested delay.
    task automatic run_random(input int count, input int tick_pct, input int sec_max);
        logic cmd;
        for (int n = 0; n < count; n++) begin
            cmd = ($urandom_range(0, 99) < tick_pct) ? etmr_pkg::CMD_TICK : etmr_pkg::CMD_SET;
            send_cmd(cmd, etmr_pkg::SEC_W'($urandom_range(0, sec_max)),
                     etmr_pkg::OWNER_W'($urandom_range(0, 65535)));
        end
    endtask

    // Stop offering, wait for every pending result, then let a silent tick finish.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write ticks per second; only called while the block is idle.
    task automatic write_rate(input logic [etmr_pkg::TPS_W-1:0] rate);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = rate;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        sb.set_rate(rate);
    endtask

    // Result side: random backpressure, one long hold-off on request, and a
    // check of every result transaction against the oldest prediction.
    initial begin
        int wait_n;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            wait_n = draw_wait(rx_quiet);
            @(negedge i_clk);
            if (hold_output) begin
                // hold off long enough for the table to back up into the input
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_output = 1'b0;
            end else if (wait_n > 0) begin
                m_axis_tready = 1'b0;
                repeat (wait_n) @(negedge i_clk);
            end
            m_axis_tready = 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            sb.check_result('{kind: m_axis_tuser, owner_id: m_axis_tdata[15:0],
                              slot: m_axis_tdata[20:16], last: m_axis_tlast});
        end
    end

    // Watchdog: abort when no transaction moves on either side for too long.
    initial begin
        int still_cycles;
        still_cycles = 0;
        while (still_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                still_cycles = 0;
            else
                still_cycles++;
        end
        $display("tb_expiry_timer_table: FAIL");
        $finish;
    end

    initial begin
        sb            = new();
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = etmr_pkg::TPS_RESET;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = etmr_pkg::CMD_TICK;
        hold_output   = 1'b0;
        tx_quiet      = 0;
        rx_quiet      = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset rate of 100: tick on an empty table, zero-second timers at the
        // owner extremes, one timer that falls due a hundred ticks later.
        send_cmd(etmr_pkg::CMD_TICK, 16'h0000, 16'h0000);
        send_cmd(etmr_pkg::CMD_SET,  16'h0000, 16'h0000);
        send_cmd(etmr_pkg::CMD_SET,  16'h0000, 16'hFFFF);
        send_cmd(etmr_pkg::CMD_SET,  16'h0001, 16'h1234);
        send_cmd(etmr_pkg::CMD_TICK, 16'hFFFF, 16'hFFFF);
        run_random(40, 50, 1);
        drain();

        // Zero rate: any delay expires on the next tick, so sweep the full
        // seconds range.
        write_rate(etmr_pkg::TPS_W'(0));
        send_cmd(etmr_pkg::CMD_SET,  16'hFFFF, 16'hA5A5);
        send_cmd(etmr_pkg::CMD_SET,  16'h8000, 16'h5A5A);
        send_cmd(etmr_pkg::CMD_TICK, 16'h0000, 16'h0000);
        run_random(100, 40, 65535);

        // Fill the table past its end, then free it all with one tick.
        repeat (TABLE_SLOTS + 3)
            send_cmd(etmr_pkg::CMD_SET, etmr_pkg::SEC_W'($urandom_range(0, 65535)),
                     etmr_pkg::OWNER_W'($urandom_range(0, 65535)));
        send_cmd(etmr_pkg::CMD_TICK, 16'h0000, 16'h0000);
        drain();

        // Lowest nonzero rate: short delays overlap and expire out of set order.
        write_rate(etmr_pkg::TPS_W'(1));
        run_random(100, 50, 7);
        drain();

        // Widest rate: one timer with the largest product parks in its slot for
        // good; the rest use zero seconds.
        write_rate({etmr_pkg::TPS_W{1'b1}});
        send_cmd(etmr_pkg::CMD_SET, 16'hFFFF, 16'hC3C3);
        run_random(60, 50, 0);
        drain();

        write_rate(etmr_pkg::TPS_W'(10000));
        run_random(40, 50, 0);
        drain();

        // Small rate under a long result-side hold-off while commands keep coming.
        write_rate(etmr_pkg::TPS_W'(3));
        hold_output = 1'b1;
        run_random(100, 45, 3);
        drain();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_expiry_timer_table: PASS");
        else
            $display("tb_expiry_timer_table: FAIL");
        $finish;
    end

endmodule
